/* rtl/core/nsc_pkg.sv */
// shared types, codes and defaults for the nfa subset construction unit
package nsc_pkg;

  localparam int unsigned NfaStatesDef  = 16;
  localparam int unsigned SymbolsDef    = 16;
  localparam int unsigned MaxSubsetsDef = 256;

  localparam int unsigned ActionW   = 2;
  localparam int unsigned StateIdxW = 4;
  localparam int unsigned SymIdxW   = 4;
  localparam int unsigned KindW     = 2;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned SymCntW   = 5;
  localparam int unsigned FinalW    = 16;

  localparam logic [SymCntW-1:0] SymCountRst = 5'd16;

  typedef enum logic [ActionW-1:0] {
    ACT_ADD    = 2'd0,
    ACT_EXPAND = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NOP    = 2'd3
  } action_e;

  typedef enum logic [KindW-1:0] {
    KIND_TRANS   = 2'd0,
    KIND_SUMMARY = 2'd1,
    KIND_NONE    = 2'd2
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SYM_COUNT   = 2'd0,
    CFG_START_STATE = 2'd1,
    CFG_FINAL_MASK  = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_EXP_RD,
    ST_EXP_FROM,
    ST_SYM,
    ST_OR,
    ST_CHECK,
    ST_SEARCH,
    ST_RECORD,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_SUMMARY,
    ST_NONE
  } state_e;

endpackage

/* rtl/core/nsc_ram.sv */
// single port write, single port read synchronous memory
module nsc_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/nfa_subset_construction_unit.sv */
// top level: subset construction sequencer around table, list and result memories
// add: read the successor entry, then write it back with the to-state bit set
// expand: pop an entry, OR the successor rows per used symbol, search the list for each
//   nonempty union and record it; then emit the transitions and a summary
// one item at a time; in_ready_o is high only when the sequencer is idle
// reset: async active low, then a pass zeroes the successor table, as ACT_CLEAR also does
module nfa_subset_construction_unit
  import nsc_pkg::*;
#(
  parameter int unsigned NFA_STATES  = NfaStatesDef,
  parameter int unsigned SYMBOLS     = SymbolsDef,
  parameter int unsigned MAX_SUBSETS = MaxSubsetsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [CfgIdxW-1:0]                 cfg_index_i,
  input  logic [CfgDataW-1:0]                cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [ActionW-1:0]                 action_i,
  input  logic [StateIdxW-1:0]               from_state_i,
  input  logic [SymIdxW-1:0]                 symbol_i,
  input  logic [StateIdxW-1:0]               to_state_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [KindW-1:0]                   kind_o,
  output logic [NFA_STATES-1:0]              from_set_o,
  output logic [SymIdxW-1:0]                 out_symbol_o,
  output logic [NFA_STATES-1:0]              to_set_o,
  output logic                               first_seen_o,
  output logic                               is_final_o,
  output logic [$clog2(MAX_SUBSETS+1)-1:0]   pending_o,
  output logic                               overflow_o,
  output logic                               last_o
);

  localparam int unsigned N     = NFA_STATES;
  localparam int unsigned TDEP  = NFA_STATES * SYMBOLS;
  localparam int unsigned SW    = $clog2(N);
  localparam int unsigned YW    = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int unsigned YCW   = $clog2(SYMBOLS + 1);
  localparam int unsigned PCW   = $clog2(N + 1);
  localparam int unsigned TAW   = $clog2(TDEP);
  localparam int unsigned CCW   = $clog2(TDEP + 1);
  localparam int unsigned LAW   = $clog2(MAX_SUBSETS);
  localparam int unsigned LCW   = $clog2(MAX_SUBSETS + 1);
  localparam int unsigned BDEP  = (SYMBOLS > 1) ? SYMBOLS : 2;
  localparam int unsigned BAW   = $clog2(BDEP);
  localparam int unsigned BW    = YW + N + 1;

  state_e state_q, state_d;

  logic [SymCntW-1:0] sym_count_q;
  logic [SW-1:0]      start_q;
  logic [FinalW-1:0]  final_q;

  logic [LCW-1:0] count_q, count_d;
  logic [LCW-1:0] head_q, head_d;
  logic           ovf_q, ovf_d;
  logic           seed_q, seed_d;
  logic [CCW-1:0] clr_q, clr_d;

  logic [SW-1:0]  rfs_q, rfs_d;
  logic [YW-1:0]  rsy_q, rsy_d;
  logic [SW-1:0]  rts_q, rts_d;

  logic [N-1:0]   from_q, from_d;
  logic [YCW-1:0] sym_q, sym_d;
  logic [PCW-1:0] p_q, p_d;
  logic           tv_q, tv_d;
  logic [N-1:0]   acc_q, acc_d;
  logic [LCW-1:0] i_q, i_d;
  logic           lv_q, lv_d;
  logic           found_q, found_d;
  logic [YCW-1:0] nres_q, nres_d;
  logic [YCW-1:0] eidx_q, eidx_d;

  logic                out_valid_q, out_valid_d;
  logic [KindW-1:0]    kind_q, kind_d;
  logic [N-1:0]        ofrom_q, ofrom_d;
  logic [SymIdxW-1:0]  osym_q, osym_d;
  logic [N-1:0]        oto_q, oto_d;
  logic                oseen_q, oseen_d;
  logic                ofin_q, ofin_d;
  logic [LCW-1:0]      opend_q, opend_d;
  logic                oovf_q, oovf_d;
  logic                olast_q, olast_d;

  logic           t_we, t_re;
  logic [TAW-1:0] t_waddr, t_raddr;
  logic [N-1:0]   t_wdata, t_rdata;
  logic           l_we, l_re;
  logic [LAW-1:0] l_waddr, l_raddr;
  logic [N-1:0]   l_wdata, l_rdata;
  logic           b_we, b_re;
  logic [BAW-1:0] b_waddr, b_raddr;
  logic [BW-1:0]  b_wdata, b_rdata;

  logic           in_acc, out_free;
  logic [YCW-1:0] nsym;
  logic [SW-1:0]  st_idx;
  logic [TAW-1:0] rule_addr, or_addr;
  logic           seen;

  nsc_ram #(.DEPTH(TDEP), .WIDTH(N)) u_table (
    .clk_i, .we_i(t_we), .waddr_i(t_waddr), .wdata_i(t_wdata),
    .re_i(t_re), .raddr_i(t_raddr), .rdata_o(t_rdata)
  );

  nsc_ram #(.DEPTH(MAX_SUBSETS), .WIDTH(N)) u_list (
    .clk_i, .we_i(l_we), .waddr_i(l_waddr), .wdata_i(l_wdata),
    .re_i(l_re), .raddr_i(l_raddr), .rdata_o(l_rdata)
  );

  nsc_ram #(.DEPTH(BDEP), .WIDTH(BW)) u_results (
    .clk_i, .we_i(b_we), .waddr_i(b_waddr), .wdata_i(b_wdata),
    .re_i(b_re), .raddr_i(b_raddr), .rdata_o(b_rdata)
  );

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_count_q <= SymCountRst;
      start_q     <= '0;
      final_q     <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SYM_COUNT:   sym_count_q <= cfg_data_i[SymCntW-1:0];
        CFG_START_STATE: start_q     <= SW'(32'(cfg_data_i[StateIdxW-1:0]) < N ?
                                          32'(cfg_data_i[StateIdxW-1:0]) : N - 1);
        CFG_FINAL_MASK:  final_q     <= cfg_data_i[FinalW-1:0];
        default: ;
      endcase
    end
  end

  assign st_idx   = start_q;
  assign nsym     = (32'(sym_count_q) > SYMBOLS) ? YCW'(SYMBOLS) : YCW'(32'(sym_count_q));
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign rule_addr = TAW'(32'(rfs_q) * SYMBOLS + 32'(rsy_q));
  assign or_addr   = TAW'(32'(p_q) * SYMBOLS + 32'(sym_q));

  always_comb begin
    state_d = state_q;
    count_d = count_q; head_d = head_q; ovf_d = ovf_q; seed_d = seed_q; clr_d = clr_q;
    rfs_d = rfs_q; rsy_d = rsy_q; rts_d = rts_q;
    from_d = from_q; sym_d = sym_q; p_d = p_q; tv_d = 1'b0; acc_d = acc_q;
    i_d = i_q; lv_d = 1'b0; found_d = found_q; nres_d = nres_q; eidx_d = eidx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    kind_d = kind_q; ofrom_d = ofrom_q; osym_d = osym_q; oto_d = oto_q;
    oseen_d = oseen_q; ofin_d = ofin_q; opend_d = opend_q; oovf_d = oovf_q;
    olast_d = olast_q;
    t_we = 1'b0; t_waddr = rule_addr; t_wdata = '0; t_re = 1'b0; t_raddr = rule_addr;
    l_we = 1'b0; l_waddr = count_q[LAW-1:0]; l_wdata = acc_q;
    l_re = 1'b0; l_raddr = head_q[LAW-1:0];
    b_we = 1'b0; b_waddr = nres_q[BAW-1:0]; b_wdata = '0;
    b_re = 1'b0; b_raddr = eidx_q[BAW-1:0];
    seen = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        t_we    = 1'b1;
        t_waddr = clr_q[TAW-1:0];
        clr_d   = clr_q + 1'b1;
        if (32'(clr_q) == TDEP - 1) begin
          state_d = ST_IDLE;
          if (seed_q) begin
            l_we    = 1'b1;
            l_waddr = '0;
            l_wdata = N'(1) << st_idx;
            count_d = LCW'(1);
            head_d  = '0;
            ovf_d   = 1'b0;
            seed_d  = 1'b0;
          end
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (action_i)
            ACT_ADD: begin
              if (32'(from_state_i) < N && 32'(symbol_i) < SYMBOLS && 32'(to_state_i) < N) begin
                rfs_d   = SW'(32'(from_state_i));
                rsy_d   = YW'(32'(symbol_i));
                rts_d   = SW'(32'(to_state_i));
                state_d = ST_ADD_RD;
              end
            end
            ACT_EXPAND: begin
              state_d = (head_q < count_q) ? ST_EXP_RD : ST_NONE;
            end
            ACT_CLEAR: begin
              clr_d   = '0;
              seed_d  = 1'b1;
              state_d = ST_CLEAR;
            end
            default: ;
          endcase
        end
      end
      ST_ADD_RD: begin
        t_re    = 1'b1;
        state_d = ST_ADD_WR;
      end
      ST_ADD_WR: begin
        t_we    = 1'b1;
        t_wdata = t_rdata | (N'(1) << rts_q);
        state_d = ST_IDLE;
      end
      ST_EXP_RD: begin
        l_re    = 1'b1;
        head_d  = head_q + 1'b1;
        sym_d   = '0;
        nres_d  = '0;
        state_d = ST_EXP_FROM;
      end
      ST_EXP_FROM: begin
        from_d  = l_rdata;
        state_d = ST_SYM;
      end
      ST_SYM: begin
        if (sym_q >= nsym) begin
          eidx_d  = '0;
          state_d = (nres_q == '0) ? ST_SUMMARY : ST_EMIT_RD;
        end else begin
          p_d     = '0;
          acc_d   = '0;
          state_d = ST_OR;
        end
      end
      ST_OR: begin
        if (tv_q) begin
          acc_d = acc_q | t_rdata;
        end
        if (32'(p_q) < N) begin
          t_re    = 1'b1;
          t_raddr = or_addr;
          tv_d    = from_q[p_q[SW-1:0]];
          p_d     = p_q + 1'b1;
        end else begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (acc_q == '0) begin
          sym_d   = sym_q + 1'b1;
          state_d = ST_SYM;
        end else begin
          i_d     = '0;
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (lv_q && l_rdata == acc_q) begin
          found_d = 1'b1;
          state_d = ST_RECORD;
        end else if (i_q < count_q) begin
          l_re    = 1'b1;
          l_raddr = i_q[LAW-1:0];
          lv_d    = 1'b1;
          i_d     = i_q + 1'b1;
        end else begin
          found_d = 1'b0;
          state_d = ST_RECORD;
        end
      end
      ST_RECORD: begin
        if (!found_q) begin
          if (32'(count_q) < MAX_SUBSETS) begin
            l_we    = 1'b1;
            count_d = count_q + 1'b1;
            seen    = 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
        end
        b_we    = 1'b1;
        b_wdata = {sym_q[YW-1:0], acc_q, seen};
        nres_d  = nres_q + 1'b1;
        sym_d   = sym_q + 1'b1;
        state_d = ST_SYM;
      end
      ST_EMIT_RD: begin
        b_re    = 1'b1;
        state_d = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          kind_d  = KIND_TRANS;
          ofrom_d = from_q;
          osym_d  = SymIdxW'(32'(b_rdata[BW-1 -: YW]));
          oto_d   = b_rdata[N:1];
          oseen_d = b_rdata[0];
          ofin_d  = 1'b0;
          opend_d = count_q - head_q;
          oovf_d  = ovf_q;
          olast_d = 1'b0;
          eidx_d  = eidx_q + 1'b1;
          state_d = (eidx_q + 1'b1 < nres_q) ? ST_EMIT_RD : ST_SUMMARY;
        end
      end
      ST_SUMMARY: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          kind_d  = KIND_SUMMARY;
          ofrom_d = from_q;
          osym_d  = '0;
          oto_d   = '0;
          oseen_d = 1'b0;
          ofin_d  = |(32'(from_q) & 32'(final_q));
          opend_d = count_q - head_q;
          oovf_d  = ovf_q;
          olast_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_NONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          kind_d  = KIND_NONE;
          ofrom_d = '0;
          osym_d  = '0;
          oto_d   = '0;
          oseen_d = 1'b0;
          ofin_d  = 1'b0;
          opend_d = '0;
          oovf_d  = ovf_q;
          olast_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      count_q     <= '0;
      head_q      <= '0;
      ovf_q       <= 1'b0;
      seed_q      <= 1'b0;
      clr_q       <= '0;
      tv_q        <= 1'b0;
      lv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      head_q      <= head_d;
      ovf_q       <= ovf_d;
      seed_q      <= seed_d;
      clr_q       <= clr_d;
      tv_q        <= tv_d;
      lv_q        <= lv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rfs_q   <= rfs_d;
    rsy_q   <= rsy_d;
    rts_q   <= rts_d;
    from_q  <= from_d;
    sym_q   <= sym_d;
    p_q     <= p_d;
    acc_q   <= acc_d;
    i_q     <= i_d;
    found_q <= found_d;
    nres_q  <= nres_d;
    eidx_q  <= eidx_d;
    kind_q  <= kind_d;
    ofrom_q <= ofrom_d;
    osym_q  <= osym_d;
    oto_q   <= oto_d;
    oseen_q <= oseen_d;
    ofin_q  <= ofin_d;
    opend_q <= opend_d;
    oovf_q  <= oovf_d;
    olast_q <= olast_d;
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign from_set_o   = ofrom_q;
  assign out_symbol_o = osym_q;
  assign to_set_o     = oto_q;
  assign first_seen_o = oseen_q;
  assign is_final_o   = ofin_q;
  assign pending_o    = opend_q;
  assign overflow_o   = oovf_q;
  assign last_o       = olast_q;

endmodule
